>>> rtl/xxtea_pkg.sv
// ============================================================================
// XXTEA package
// Shared constants, register indexes and the controller-to-datapath command.
// ============================================================================
`default_nettype none

package xxtea_pkg;

   // Key schedule increment (golden ratio constant)
   localparam logic [31:0] ROUND_DELTA = 32'h9E37_79B9;

   // Round count formula terms: 6 + 52 / words
   localparam int ROUND_BASE  = 6;
   localparam int ROUND_SPAN  = 52;

   // Register indexes of the configuration port
   typedef enum logic [2:0] {
      REG_KEY_ZERO  = 3'd0,
      REG_KEY_ONE   = 3'd1,
      REG_KEY_TWO   = 3'd2,
      REG_KEY_THREE = 3'd3,
      REG_MODE      = 3'd4
   } reg_index_type;

   // Per-cycle command from the controller to the datapath
   typedef struct packed {
      logic       load;       // write an incoming word into the block store
      logic       first;      // incoming word is word zero of the block
      logic       start;      // last word arrived: seed the running registers
      logic       step;       // perform one word update
      logic       round_end;  // this update closes a round
      logic       emit;       // read one result word for output
      logic       last;       // the emitted word is the final one
      logic       decrypt;    // direction of the current block
      logic [1:0] pos_low;    // low bits of the word position for key select
   } dp_cmd_type;

endpackage

`default_nettype wire

>>> rtl/xxtea_block_cipher_16_word_unit.sv
// ============================================================================
// XXTEA block cipher unit
// Loads a block word by word, encrypts or decrypts it, streams the result.
// ============================================================================
// Loading takes one word per cycle. After the last word: a fetch state,
// then (6 + 52/BLOCK_WORDS) rounds of BLOCK_WORDS word updates, then one
// result per cycle, BLOCK_WORDS in all, with registered strobe and data.
// Block time is set by the single mixing unit and the one write port of
// the block store. Reset clears control state, keys, mode and flags;
// the data registers and the block store are not cleared.
`default_nettype none

module xxtea_block_cipher_16_word_unit #(
   parameter int BLOCK_WORDS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // command channel
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [31:0] req_block_word,
   // result channel
   output      logic        rsp_strobe,
   output      logic [31:0] rsp_result_word,
   output      logic        rsp_last_word,
   // configuration port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready
);

   localparam int AW = $clog2(BLOCK_WORDS);

   logic [3:0][31:0]         key_ff;
   logic                     mode_ff;
   logic                     csr_wr;
   xxtea_pkg::reg_index_type csr_idx;
   xxtea_pkg::dp_cmd_type    cmd;
   logic [AW-1:0]            wr_addr;
   logic [AW-1:0]            rd_addr;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = xxtea_pkg::reg_index_type'(paddr[4:2]);

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= '0;
         mode_ff <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            xxtea_pkg::REG_KEY_ZERO:  key_ff[0] <= pwdata;
            xxtea_pkg::REG_KEY_ONE:   key_ff[1] <= pwdata;
            xxtea_pkg::REG_KEY_TWO:   key_ff[2] <= pwdata;
            xxtea_pkg::REG_KEY_THREE: key_ff[3] <= pwdata;
            xxtea_pkg::REG_MODE:      mode_ff   <= pwdata[0];
            default: begin
            end
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (csr_idx)
         xxtea_pkg::REG_KEY_ZERO:  prdata = key_ff[0];
         xxtea_pkg::REG_KEY_ONE:   prdata = key_ff[1];
         xxtea_pkg::REG_KEY_TWO:   prdata = key_ff[2];
         xxtea_pkg::REG_KEY_THREE: prdata = key_ff[3];
         xxtea_pkg::REG_MODE:      prdata = {31'b0, mode_ff};
         default:                  prdata = '0;
      endcase
   end

   xxtea_ctrl #(
      .BLOCK_WORDS(BLOCK_WORDS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .cfg_decrypt(mode_ff),
      .busy       (busy),
      .cmd        (cmd),
      .wr_addr    (wr_addr),
      .rd_addr    (rd_addr)
   );

   xxtea_dp #(
      .BLOCK_WORDS(BLOCK_WORDS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .in_word   (req_block_word),
      .key_words (key_ff),
      .out_strobe(rsp_strobe),
      .out_word  (rsp_result_word),
      .out_last  (rsp_last_word)
   );

   // Results appear only as the tail of a busy period
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a running block");

   // The last-word marker rides only on a strobe
   a_last_with_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last_word |-> rsp_strobe)
      else $error("last marker without result strobe");

   // Final word ends the result burst
   a_burst_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_word) |=> !rsp_strobe)
      else $error("result strobe after final word");

   // A run begins only on an accepted transfer
   a_busy_from_transfer: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !busy))
      else $error("busy raised without an accepted transfer");

endmodule

`default_nettype wire

>>> rtl/xxtea_ram.sv
// ============================================================================
// XXTEA generic RAM
// One write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module xxtea_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/xxtea_ctrl.sv
// ============================================================================
// XXTEA controller
// Sequences loading, the word-update rounds and result emission.
// ============================================================================
`default_nettype none

module xxtea_ctrl #(
   parameter int BLOCK_WORDS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic                           cfg_decrypt,
   output      logic                           busy,
   output      xxtea_pkg::dp_cmd_type          cmd,
   output      logic [$clog2(BLOCK_WORDS)-1:0] wr_addr,
   output      logic [$clog2(BLOCK_WORDS)-1:0] rd_addr
);

   localparam int AW     = $clog2(BLOCK_WORDS);
   localparam int PW     = (AW < 2) ? 2 : AW;
   localparam int ROUNDS = xxtea_pkg::ROUND_BASE + xxtea_pkg::ROUND_SPAN / BLOCK_WORDS;
   localparam int RW     = $clog2(ROUNDS);
   localparam logic [AW-1:0] LAST_POS   = AW'(BLOCK_WORDS - 1);
   localparam logic [RW-1:0] LAST_ROUND = RW'(ROUNDS - 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PRIME = 4'b0010,
      ST_RUN   = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type      state_ff, state_in;
   logic [AW-1:0]  load_cnt_ff, load_cnt_in;
   logic [AW-1:0]  pos_ff, pos_in;
   logic [RW-1:0]  round_ff, round_in;
   logic           mode_ff, mode_in;
   logic [PW-1:0]  pos_wide;
   logic           round_done;

   // Step a word position one place in the direction of the current pass
   function automatic logic [AW-1:0] advance(input logic [AW-1:0] p, input logic dec);
      logic [AW-1:0] r;
      if (dec) begin
         r = (p == '0) ? LAST_POS : p - AW'(1);
      end else begin
         r = (p == LAST_POS) ? '0 : p + AW'(1);
      end
      return r;
   endfunction

   assign pos_wide   = PW'(pos_ff);
   assign round_done = mode_ff ? (pos_ff == '0) : (pos_ff == LAST_POS);
   assign busy       = (state_ff != ST_IDLE);

   // Next-state and command decode
   always_comb begin
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      pos_in      = pos_ff;
      round_in    = round_ff;
      mode_in     = mode_ff;
      cmd         = '0;
      cmd.decrypt = mode_ff;
      cmd.pos_low = pos_wide[1:0];
      wr_addr     = pos_ff;
      rd_addr     = pos_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load  = 1'b1;
               cmd.first = (load_cnt_ff == '0);
               wr_addr   = load_cnt_ff;
               if (load_cnt_ff == LAST_POS) begin
                  cmd.start   = 1'b1;
                  cmd.decrypt = cfg_decrypt;
                  mode_in     = cfg_decrypt;
                  load_cnt_in = '0;
                  round_in    = '0;
                  pos_in      = cfg_decrypt ? LAST_POS : '0;
                  state_in    = ST_PRIME;
               end else begin
                  load_cnt_in = load_cnt_ff + AW'(1);
               end
            end
         end
         ST_PRIME: begin
            // fetch the neighbor of the first word to update
            rd_addr  = advance(pos_ff, mode_ff);
            state_in = ST_RUN;
         end
         ST_RUN: begin
            cmd.step      = 1'b1;
            cmd.round_end = round_done;
            rd_addr       = advance(advance(pos_ff, mode_ff), mode_ff);
            pos_in        = advance(pos_ff, mode_ff);
            if (round_done) begin
               if (round_ff == LAST_ROUND) begin
                  round_in = '0;
                  pos_in   = '0;
                  state_in = ST_EMIT;
               end else begin
                  round_in = round_ff + RW'(1);
               end
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            cmd.last = (pos_ff == LAST_POS);
            pos_in   = pos_ff + AW'(1);
            if (pos_ff == LAST_POS) begin
               pos_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         load_cnt_ff <= '0;
         pos_ff      <= '0;
         round_ff    <= '0;
         mode_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         pos_ff      <= pos_in;
         round_ff    <= round_in;
         mode_ff     <= mode_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/xxtea_dp.sv
// ============================================================================
// XXTEA datapath
// Block store, one mixing unit and the running key schedule sum.
// ============================================================================
`default_nettype none

module xxtea_dp #(
   parameter int BLOCK_WORDS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire xxtea_pkg::dp_cmd_type          cmd,
   input  wire logic [$clog2(BLOCK_WORDS)-1:0] wr_addr,
   input  wire logic [$clog2(BLOCK_WORDS)-1:0] rd_addr,
   input  wire logic [31:0]                    in_word,
   input  wire logic [3:0][31:0]               key_words,
   output      logic                           out_strobe,
   output      logic [31:0]                    out_word,
   output      logic                           out_last
);

   localparam int ROUNDS = xxtea_pkg::ROUND_BASE + xxtea_pkg::ROUND_SPAN / BLOCK_WORDS;
   localparam logic [63:0] DEC_SUM_FULL = 64'(ROUNDS) * 64'(xxtea_pkg::ROUND_DELTA);
   localparam logic [31:0] DEC_SUM_INIT = DEC_SUM_FULL[31:0];

   logic [31:0] first_ff, first_in;
   logic [31:0] carry_ff, carry_in;
   logic [31:0] cur_ff, cur_in;
   logic [31:0] sum_ff, sum_in;
   logic        byp_ff;
   logic [31:0] byp_data_ff;
   logic        strobe_ff;
   logic        last_ff;

   logic        ram_we;
   logic [31:0] ram_wdata;
   logic [31:0] ram_rdata;
   logic [31:0] nbr;
   logic [31:0] mz, my, mix_a, mix_b, mix_val, new_word;
   logic [1:0]  key_sel;

   xxtea_ram #(
      .WIDTH(32),
      .DEPTH(BLOCK_WORDS)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .waddr(wr_addr),
      .wdata(ram_wdata),
      .raddr(rd_addr),
      .rdata(ram_rdata)
   );

   // Neighbor word, forwarded when it was written on the edge it was read
   assign nbr = byp_ff ? byp_data_ff : ram_rdata;

   // Mix function: z is the word before, y the word after the one updated
   assign mz      = cmd.decrypt ? nbr : carry_ff;
   assign my      = cmd.decrypt ? carry_ff : nbr;
   assign key_sel = cmd.pos_low ^ sum_ff[3:2];
   assign mix_a   = ((mz >> 5) ^ (my << 2)) + ((my >> 3) ^ (mz << 4));
   assign mix_b   = (sum_ff ^ my) + (key_words[key_sel] ^ mz);
   assign mix_val = mix_a ^ mix_b;
   assign new_word = cmd.decrypt ? (cur_ff - mix_val) : (cur_ff + mix_val);

   // Store write: loaded word or updated word
   assign ram_we    = cmd.load | cmd.step;
   assign ram_wdata = cmd.load ? in_word : new_word;

   // Running registers
   always_comb begin
      first_in = first_ff;
      carry_in = carry_ff;
      cur_in   = cur_ff;
      sum_in   = sum_ff;
      if (cmd.first) begin
         first_in = in_word;
      end
      if (cmd.start) begin
         carry_in = cmd.decrypt ? first_ff : in_word;
         cur_in   = cmd.decrypt ? in_word : first_ff;
         sum_in   = cmd.decrypt ? DEC_SUM_INIT : xxtea_pkg::ROUND_DELTA;
      end else if (cmd.step) begin
         carry_in = new_word;
         cur_in   = nbr;
         if (cmd.round_end) begin
            sum_in = cmd.decrypt ? (sum_ff - xxtea_pkg::ROUND_DELTA)
                                 : (sum_ff + xxtea_pkg::ROUND_DELTA);
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      first_ff    <= first_in;
      carry_ff    <= carry_in;
      cur_ff      <= cur_in;
      sum_ff      <= sum_in;
      byp_data_ff <= ram_wdata;
      last_ff     <= cmd.last;
   end

   // Control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         byp_ff    <= ram_we && (wr_addr == rd_addr);
         strobe_ff <= cmd.emit;
      end
   end

   assign out_strobe = strobe_ff;
   assign out_word   = ram_rdata;
   assign out_last   = last_ff;

endmodule

`default_nettype wire
